// ----- hw/rtl/dpwq_pkg.sv -----
// ----------------------------------------------------------------------------
// dpwq_pkg
// Shared constants, codes and types of the driver projected waveform queue.
// ----------------------------------------------------------------------------
package dpwq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SIGNAL_BITS = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Keep only SIGNAL_BITS logic codes of a packed value
  localparam logic [31:0] VALUE_MASK = 32'((64'(1) << (SIGNAL_BITS * 4)) - 64'(1));

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_WAVE = 2'd1,
    ST_BAD_REJ  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FLAGS,
    S_PLAN,
    S_DELETE,
    S_APPEND
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt_first;
    logic lt_thr;
    logic eq_ref;
  } cell_flags_t;

endpackage

// ----- hw/rtl/dpwq_req_if.sv -----
// ----------------------------------------------------------------------------
// dpwq_req_if
// Request channel: waveform elements and ticks.
// ----------------------------------------------------------------------------
interface dpwq_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] delay;
  logic [31:0] element_value;
  logic [31:0] rejection_limit;
  logic        inertial;
  logic        last_element;

  modport source (output valid, opcode, delay, element_value, rejection_limit,
                  inertial, last_element, input ready);
  modport sink (input valid, opcode, delay, element_value, rejection_limit,
                inertial, last_element, output ready);
endinterface

// ----- hw/rtl/dpwq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dpwq_rsp_if
// Response channel: one result word per request word.
// ----------------------------------------------------------------------------
interface dpwq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        committed;
  logic [31:0] driver_value;
  logic [4:0]  pending_count;

  modport source (output valid, status, committed, driver_value, pending_count,
                  input ready);
  modport sink (input valid, status, committed, driver_value, pending_count,
                output ready);
endinterface

// ----- hw/rtl/dpwq_scell.sv -----
// ----------------------------------------------------------------------------
// dpwq_scell
// One staging cell: holds a waveform element until it moves to the queue.
// ----------------------------------------------------------------------------
module dpwq_scell
  import dpwq_pkg::*;
(
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic [31:0] nb_delay,
  input  logic [31:0] nb_value,
  input  logic [31:0] ld_delay,
  input  logic [31:0] ld_value,
  output logic [31:0] delay,
  output logic [31:0] value
);

  // load wins; shift pulls from the neighbor above
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      delay <= ld_delay;
      value <= ld_value;
    end else if (ctrl.shift) begin
      delay <= nb_delay;
      value <= nb_value;
    end
  end

endmodule

// ----- hw/rtl/dpwq_qcell.sv -----
// ----------------------------------------------------------------------------
// dpwq_qcell
// One queue cell: a pending transaction and its compare flags.
// ----------------------------------------------------------------------------
module dpwq_qcell
  import dpwq_pkg::*;
(
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic [63:0] nb_time,
  input  logic [31:0] nb_value,
  input  logic [63:0] ld_time,
  input  logic [31:0] ld_value,
  input  logic [63:0] wave_start,
  input  logic [63:0] threshold,
  input  logic [31:0] ref_value,
  output logic [63:0] time_q,
  output logic [31:0] value_q,
  output cell_flags_t flags
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      time_q  <= ld_time;
      value_q <= ld_value;
    end else if (ctrl.shift) begin
      time_q  <= nb_time;
      value_q <= nb_value;
    end
  end

  assign flags.lt_first = time_q < wave_start;
  assign flags.lt_thr   = time_q < threshold;
  assign flags.eq_ref   = value_q == ref_value;

endmodule

// ----- hw/rtl/driver_projected_waveform_queue.sv -----
// ----------------------------------------------------------------------------
// driver_projected_waveform_queue
// Pending transaction queue of one signal driver, kept in a chain of cells.
// ----------------------------------------------------------------------------
// Result timing: a tick or a non-final element loads its result word at the
//   accepting edge. A final element loads it after the check, flags and plan
//   states, D pruned entries closed one per cycle and N new elements moved one
//   per cycle; D + N <= QUEUE_DEPTH. Errors load it from the check or plan state.
// Throughput: one word at a time; the next word is taken once the result word
//   slot is free and the update sequence is done.
// Reset (rst, synchronous): time, counts, staging flags and driver value clear.
// ----------------------------------------------------------------------------
module driver_projected_waveform_queue
  import dpwq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  dpwq_req_if.sink    req,
  dpwq_rsp_if.source  rsp
);

  state_t state, state_next;

  logic [63:0]      now;
  logic [CNT_W-1:0] count;
  logic [31:0]      drv;
  logic [CNT_W-1:0] stg_n;
  logic [1:0]       stg_err;
  logic [31:0]      stg_rej;
  logic             stg_mode;
  logic [31:0]      first_delay;
  logic [31:0]      last_delay;
  logic [63:0]      wave_start;
  logic [CNT_W-1:0] cut_a;
  logic [CNT_W-1:0] del_n;
  logic [QUEUE_DEPTH-1:0] lt_first_v, lt_thr_v, eq_v;

  // Cell chains
  logic [63:0] q_time  [QUEUE_DEPTH];
  logic [31:0] q_value [QUEUE_DEPTH];
  cell_flags_t q_flags [QUEUE_DEPTH];
  logic [31:0] s_delay [QUEUE_DEPTH];
  logic [31:0] s_value [QUEUE_DEPTH];

  logic [63:0] threshold;
  logic        req_fire;

  // Sequencer controls
  logic             q_shift, q_load, s_shift, s_load;
  logic [CNT_W-1:0] shift_base;
  logic             res_load, res_committed, fin_clear;
  status_t          res_status;
  logic [31:0]      res_drv;
  logic [CNT_W-1:0] res_cnt;
  logic             commit;
  logic [64:0]      last_sum;
  logic [CNT_W-1:0] kept, cut_b, plan_a;
  logic [CNT_W:0]   need;
  logic             run;

  assign req.ready  = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign req_fire   = req.valid && req.ready;
  assign threshold  = wave_start - {32'd0, stg_rej};
  assign commit     = (count != '0) && (q_time[0] <= now);
  assign last_sum   = {1'b0, now} + {33'd0, last_delay};

  // ---- cell rows --------------------------------------------------------
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cells
    cell_ctrl_t  qc, sc;
    logic [63:0] nb_t;
    logic [31:0] nb_v, nb_d, nb_sv;

    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign nb_t  = '0;
      assign nb_v  = '0;
      assign nb_d  = '0;
      assign nb_sv = '0;
    end else begin : g_mid
      assign nb_t  = q_time[i+1];
      assign nb_v  = q_value[i+1];
      assign nb_d  = s_delay[i+1];
      assign nb_sv = s_value[i+1];
    end

    assign qc.shift = q_shift && (CNT_W'(i) >= shift_base);
    assign qc.load  = q_load && (CNT_W'(i) == count);
    assign sc.shift = s_shift;
    assign sc.load  = s_load && (CNT_W'(i) == stg_n);

    dpwq_qcell u_qcell (
      .clk        (clk),
      .ctrl       (qc),
      .nb_time    (nb_t),
      .nb_value   (nb_v),
      .ld_time    (now + {32'd0, s_delay[0]}),
      .ld_value   (s_value[0]),
      .wave_start (wave_start),
      .threshold  (threshold),
      .ref_value  (s_value[0]),
      .time_q     (q_time[i]),
      .value_q    (q_value[i]),
      .flags      (q_flags[i])
    );

    dpwq_scell u_scell (
      .clk      (clk),
      .ctrl     (sc),
      .nb_delay (nb_d),
      .nb_value (nb_sv),
      .ld_delay (req.delay),
      .ld_value (req.element_value & VALUE_MASK),
      .delay    (s_delay[i]),
      .value    (s_value[i])
    );
  end

  // ---- pruning plan from registered flags --------------------------------
  always_comb begin
    kept   = CNT_W'($countones(lt_first_v));
    plan_a = stg_mode ? CNT_W'($countones(lt_first_v & lt_thr_v)) : kept;
    // walk down from the last kept entry while values match the new head
    cut_b  = kept;
    run    = 1'b1;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < kept) begin
        if (run && eq_v[i]) cut_b = CNT_W'(i);
        else                run   = 1'b0;
      end
    end
    if (cut_b < plan_a) cut_b = plan_a;
    need = {1'b0, kept} + {1'b0, stg_n};
  end

  // ---- sequencer --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    q_shift       = 1'b0;
    q_load        = 1'b0;
    s_shift       = 1'b0;
    s_load        = 1'b0;
    shift_base    = '0;
    res_load      = 1'b0;
    res_committed = 1'b0;
    res_status    = ST_OK;
    res_drv       = drv;
    res_cnt       = count;
    fin_clear     = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.opcode == OP_TICK) begin
            // pop the head when it is due
            res_load = 1'b1;
            if (commit) begin
              q_shift       = 1'b1;
              res_committed = 1'b1;
              res_drv       = q_value[0];
              res_cnt       = count - CNT_W'(1);
            end
          end else begin
            s_load = stg_n < CNT_W'(QUEUE_DEPTH);
            if (req.last_element) state_next = S_CHECK;
            else                  res_load   = 1'b1;
          end
        end
      end
      S_CHECK: begin
        state_next = S_FLAGS;
        if (stg_err[1] || stg_n == '0) begin
          res_status = ST_BAD_WAVE;
        end else if (stg_mode && stg_rej > first_delay) begin
          res_status = ST_BAD_REJ;
        end else if (stg_err[0] || last_sum[64]) begin
          res_status = ST_BAD_WAVE;
        end
        if (res_status != ST_OK) begin
          res_load   = 1'b1;
          fin_clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLAGS: begin
        state_next = S_PLAN;
      end
      S_PLAN: begin
        if (need > (CNT_W + 1)'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
          res_load   = 1'b1;
          fin_clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DELETE;
        end
      end
      S_DELETE: begin
        // close the pruned gap one entry per cycle
        if (del_n != '0) begin
          q_shift    = 1'b1;
          shift_base = cut_a;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        // move staged elements to the tail one per cycle
        if (stg_n != '0) begin
          q_load  = 1'b1;
          s_shift = 1'b1;
        end else begin
          res_load   = 1'b1;
          fin_clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---- control registers ------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      now      <= '0;
      count    <= '0;
      drv      <= '0;
      stg_n    <= '0;
      stg_err  <= '0;
      stg_rej  <= '0;
      stg_mode <= 1'b0;
    end else begin
      if (cfg_we) drv <= cfg_wdata & VALUE_MASK;

      if (req_fire && req.opcode == OP_TICK) begin
        now <= now + 64'd1;
        if (commit) begin
          drv   <= q_value[0];
          count <= count - CNT_W'(1);
        end
      end

      if (req_fire && req.opcode == OP_ELEMENT) begin
        if (stg_n == '0 && stg_err == '0) begin
          stg_rej  <= req.rejection_limit;
          stg_mode <= req.inertial;
        end
        if (stg_n >= CNT_W'(QUEUE_DEPTH)) begin
          stg_err[1] <= 1'b1;
        end else begin
          if (stg_n != '0 && req.delay <= last_delay) stg_err[0] <= 1'b1;
          stg_n <= stg_n + CNT_W'(1);
        end
      end

      if (state == S_PLAN && state_next == S_DELETE) count <= kept;
      if (state == S_DELETE && del_n != '0) count <= count - CNT_W'(1);
      if (q_load) begin
        count <= count + CNT_W'(1);
        stg_n <= stg_n - CNT_W'(1);
      end

      if (fin_clear) begin
        stg_n   <= '0;
        stg_err <= '0;
      end
    end
  end

  // ---- work registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_load) begin
      last_delay <= req.delay;
      if (stg_n == '0) first_delay <= req.delay;
    end
    if (state == S_CHECK) wave_start <= now + {32'd0, first_delay};
    if (state == S_FLAGS) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        lt_first_v[i] <= q_flags[i].lt_first && (CNT_W'(i) < count);
        lt_thr_v[i]   <= q_flags[i].lt_thr;
        eq_v[i]       <= q_flags[i].eq_ref;
      end
    end
    if (state == S_PLAN) begin
      cut_a <= plan_a;
      del_n <= cut_b - plan_a;
    end else if (state == S_DELETE && del_n != '0) begin
      del_n <= del_n - CNT_W'(1);
    end
  end

  // ---- result word register ---------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.status        <= res_status;
      rsp.committed     <= res_committed;
      rsp.driver_value  <= res_drv;
      rsp.pending_count <= 5'(res_cnt);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE)
    else $error("request taken outside idle");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    q_load |-> count < CNT_W'(QUEUE_DEPTH))
    else $error("append into full queue");

  a_tick_time: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.opcode == OP_TICK |=> now == $past(now) + 64'd1)
    else $error("tick did not advance time");
`endif

endmodule

// ----- verif/driver_projected_waveform_queue_tb.sv -----
// ----------------------------------------------------------------------------
// driver_projected_waveform_queue_tb
// Self-checking bench: a directed stimulus table, then random waveforms and
// ticks under varying backpressure. Every result word is compared with a typed-in
// expectation or a cycle-free software copy of the driver queue.
// ----------------------------------------------------------------------------
module driver_projected_waveform_queue_tb
  import dpwq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One request word plus an optional typed-in expectation
  typedef struct {
    logic        op;
    logic [31:0] dly;
    logic [31:0] val;
    logic [31:0] rej;
    logic        inert;
    logic        last;
    bit          typed;
    status_t     e_st;
    logic        e_cm;
    logic [31:0] e_dv;
    logic [4:0]  e_cnt;
  } word_t;

  typedef struct {
    status_t     st;
    logic        cm;
    logic [31:0] dv;
    logic [4:0]  cnt;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  dpwq_req_if req ();
  dpwq_rsp_if rsp ();

  driver_projected_waveform_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Queue model: own copy of time, pending transactions and staging
  // --------------------------------------------------------------------------
  logic [63:0] now_t;
  logic [63:0] pend_time [QUEUE_DEPTH];
  logic [31:0] pend_val  [QUEUE_DEPTH];
  int          pend_n;
  logic [31:0] stg_dly   [QUEUE_DEPTH];
  logic [31:0] stg_val   [QUEUE_DEPTH];
  int          stg_n;
  logic [1:0]  stg_err;
  logic [31:0] stg_rej;
  logic        stg_inert;
  logic [31:0] drv_val;

  function automatic void model_reset();
    now_t = '0; pend_n = 0; stg_n = 0; stg_err = '0;
    stg_rej = '0; stg_inert = 1'b0; drv_val = '0;
  endfunction

  // Apply the staged waveform to the pending queue; return its status
  function automatic status_t apply_waveform();
    logic [63:0] t [2*QUEUE_DEPTH];
    logic [31:0] v [2*QUEUE_DEPTH];
    bit          keep [2*QUEUE_DEPTH];
    logic [63:0] first_t;
    logic [63:0] thr;
    int          kept;
    int          total;
    int          o;
    if (stg_err[1]) return ST_BAD_WAVE;
    if (stg_n == 0) return ST_BAD_WAVE;
    if (stg_inert && stg_rej > stg_dly[0]) return ST_BAD_REJ;
    if (stg_err[0] || {32'd0, stg_dly[stg_n-1]} > ~now_t) return ST_BAD_WAVE;
    first_t = now_t + {32'd0, stg_dly[0]};
    kept = 0;
    while (kept < pend_n && pend_time[kept] < first_t) kept++;
    if (kept + stg_n > QUEUE_DEPTH) return ST_FULL;
    total = kept + stg_n;
    for (int i = 0; i < kept; i++) begin
      t[i] = pend_time[i]; v[i] = pend_val[i]; keep[i] = 1;
    end
    for (int i = 0; i < stg_n; i++) begin
      t[kept+i] = now_t + {32'd0, stg_dly[i]}; v[kept+i] = stg_val[i];
      keep[kept+i] = 1;
    end
    if (stg_inert && kept != 0) begin
      thr = first_t - {32'd0, stg_rej};
      for (int i = 0; i < kept; i++) keep[i] = t[i] < thr;
      // rescue a trailing run whose value matches its successor
      for (int i = total - 2; i >= 0; i--)
        if (!keep[i] && keep[i+1] && v[i] == v[i+1]) keep[i] = 1;
    end
    o = 0;
    for (int i = 0; i < total; i++)
      if (keep[i]) begin
        pend_time[o] = t[i]; pend_val[o] = v[i]; o++;
      end
    pend_n = o;
    return ST_OK;
  endfunction

  function automatic result_t model_word(word_t w);
    result_t r;
    r.st = ST_OK;
    r.cm = 1'b0;
    if (w.op == OP_TICK) begin
      if (pend_n != 0 && pend_time[0] <= now_t) begin
        drv_val = pend_val[0];
        for (int i = 1; i < pend_n; i++) begin
          pend_time[i-1] = pend_time[i]; pend_val[i-1] = pend_val[i];
        end
        pend_n--;
        r.cm = 1'b1;
      end
      now_t++;
    end else begin
      if (stg_n == 0 && stg_err == 0) begin
        stg_rej = w.rej; stg_inert = w.inert;
      end
      if (stg_n >= QUEUE_DEPTH) stg_err[1] = 1'b1;
      else begin
        if (stg_n != 0 && w.dly <= stg_dly[stg_n-1]) stg_err[0] = 1'b1;
        stg_dly[stg_n] = w.dly;
        stg_val[stg_n] = w.val & VALUE_MASK;
        stg_n++;
      end
      if (w.last) begin
        r.st = apply_waveform();
        stg_n = 0; stg_err = '0;
      end
    end
    r.dv = drv_val;
    r.cnt = 5'(pend_n);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Channels
  // --------------------------------------------------------------------------
  word_t   send_q[$];
  word_t   in_flight[$];
  result_t expected_q[$];
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_req = 0;
  int      hold_ack = 0;
  int      hold_cycles = 0;
  int      mismatches = 0;

  // Sender: load the next word once the current one is taken
  always @(posedge clk) begin
    word_t nxt;
    if (rst) begin
      req.valid           <= 1'b0;
      req.opcode          <= OP_TICK;
      req.delay           <= '0;
      req.element_value   <= '0;
      req.rejection_limit <= '0;
      req.inertial        <= 1'b0;
      req.last_element    <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (send_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = send_q.pop_front();
        in_flight.insert(in_flight.size(), nxt);
        req.valid           <= 1'b1;
        req.opcode          <= nxt.op;
        req.delay           <= nxt.dly;
        req.element_value   <= nxt.val;
        req.rejection_limit <= nxt.rej;
        req.inertial        <= nxt.inert;
        req.last_element    <= nxt.last;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready   <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_cycles <= 400;
      rsp.ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready   <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Predict on request handshake, check on response handshake
  result_t got;
  result_t want;
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      word_t   w;
      result_t p;
      w = in_flight.pop_front();
      p = model_word(w);
      if (w.typed) begin
        p.st = w.e_st; p.cm = w.e_cm; p.dv = w.e_dv; p.cnt = w.e_cnt;
      end
      expected_q.insert(expected_q.size(), p);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      got.st = status_t'(rsp.status);
      got.cm = rsp.committed;
      got.dv = rsp.driver_value;
      got.cnt = rsp.pending_count;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result word", $realtime);
      end else begin
        want = expected_q.pop_front();
        if (got.st !== want.st || got.cm !== want.cm || got.dv !== want.dv ||
            got.cnt !== want.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch exp st=%0d cm=%0b dv=%h cnt=%0d",
                      " got st=%0d cm=%0b dv=%h cnt=%0d"},
                     $realtime, want.st, want.cm, want.dv, want.cnt,
                     rsp.status, rsp.committed, rsp.driver_value, rsp.pending_count);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  int items_sent = 0;

  function automatic word_t mk(logic op, logic [31:0] d, logic [31:0] v,
                               logic [31:0] rj, logic in, logic ls);
    word_t w;
    w.op = op; w.dly = d; w.val = v; w.rej = rj; w.inert = in; w.last = ls;
    w.typed = 0; w.e_st = ST_OK; w.e_cm = 1'b0; w.e_dv = '0; w.e_cnt = '0;
    return w;
  endfunction

  function automatic word_t mk_exp(word_t w, status_t s, logic c, logic [31:0] dv,
                                   logic [4:0] n);
    w.typed = 1; w.e_st = s; w.e_cm = c; w.e_dv = dv; w.e_cnt = n;
    return w;
  endfunction

  task automatic push_word(word_t w);
    send_q.insert(send_q.size(), w);
    items_sent++;
  endtask

  task automatic wait_sent();
    while (send_q.size() != 0) @(posedge clk);
  endtask

  // Let every expectation arrive, then the update sequence settle
  task automatic drain();
    int guard;
    wait_sent();
    guard = 0;
    while ((expected_q.size() != 0 || in_flight.size() != 0 || req.valid) &&
           guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_init_value(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    drv_val = v & VALUE_MASK;
  endtask

  // One random waveform, mostly well formed, followed by a few ticks
  task automatic add_waveform();
    int          n;
    logic [31:0] d;
    logic [31:0] pool [4];
    logic        in;
    logic [31:0] rj;
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 17) : $urandom_range(1, 4);
    d = ($urandom_range(15) == 0) ? $urandom() : $urandom_range(0, 12);
    in = logic'($urandom_range(1));
    case ($urandom_range(7))
      0: rj = $urandom();
      1: rj = d + 1;
      default: rj = $urandom_range(0, d);
    endcase
    pool[0] = 32'h2222_2222; pool[1] = 32'h3333_3333;
    pool[2] = $urandom(); pool[3] = $urandom();
    for (int i = 0; i < n; i++) begin
      push_word(mk(OP_ELEMENT, d, pool[$urandom_range(3)], $urandom(),
                   (i == 0) ? in : logic'($urandom_range(1)), i == n - 1));
      // occasionally break the strict rise of delays
      d = ($urandom_range(9) == 0) ? d : d + $urandom_range(1, 6);
    end
    repeat ($urandom_range(0, 6))
      push_word(mk(OP_TICK, $urandom(), $urandom(), $urandom(),
                   logic'($urandom_range(1)), logic'($urandom_range(1))));
  endtask

  task automatic random_phase(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(15) == 0)
        push_word(mk(OP_ELEMENT, $urandom(), $urandom(), $urandom(),
                     logic'($urandom_range(1)), 1'b1));
      else
        add_waveform();
      while (send_q.size() > 8) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table and test sequence
  // --------------------------------------------------------------------------
  word_t dir_tab[$];

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset state, delay-0 commit, rejection above first delay, repeated delays
    dir_tab = {dir_tab, mk_exp(mk(OP_TICK, 0, 0, 0, 1'b0, 1'b0),
                               ST_OK, 1'b0, 32'd0, 5'd0)};
    dir_tab = {dir_tab, mk_exp(mk(OP_ELEMENT, 0, 32'hFFFF_FFFF, 0, 1'b0, 1'b1),
                               ST_OK, 1'b0, 32'd0, 5'd1)};
    dir_tab = {dir_tab, mk_exp(mk(OP_TICK, 0, 0, 0, 1'b0, 1'b0),
                               ST_OK, 1'b1, 32'hFFFF_FFFF, 5'd0)};
    dir_tab = {dir_tab, mk_exp(mk(OP_ELEMENT, 2, 0, 3, 1'b1, 1'b1),
                               ST_BAD_REJ, 1'b0, 32'hFFFF_FFFF, 5'd0)};
    dir_tab = {dir_tab, mk_exp(mk(OP_ELEMENT, 4, 32'h1111_1111, 0, 1'b0, 1'b0),
                               ST_OK, 1'b0, 32'hFFFF_FFFF, 5'd0)};
    dir_tab = {dir_tab, mk_exp(mk(OP_ELEMENT, 4, 32'h1111_1111, 0, 1'b0, 1'b1),
                               ST_BAD_WAVE, 1'b0, 32'hFFFF_FFFF, 5'd0)};
    // largest delay with rejection equal to it, then transport deletion
    dir_tab = {dir_tab, mk(OP_ELEMENT, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF,
                           1'b1, 1'b1)};
    dir_tab = {dir_tab, mk(OP_ELEMENT, 3, 32'h8888_8888, 0, 1'b0, 1'b0)};
    dir_tab = {dir_tab, mk(OP_ELEMENT, 5, 32'h9999_9999, 0, 1'b0, 1'b1)};
    // inertial pruning keeps the entry whose value matches the new one
    dir_tab = {dir_tab, mk(OP_ELEMENT, 6, 32'h9999_9999, 6, 1'b1, 1'b1)};
    repeat (8) dir_tab = {dir_tab, mk(OP_TICK, 0, 0, 0, 1'b0, 1'b0)};
    foreach (dir_tab[i]) push_word(dir_tab[i]);
    drain();

    write_init_value(32'hFFFF_FFFF);
    tx_idle_pct = 16; rx_idle_pct = 58;
    random_phase(280);
    drain();

    write_init_value($urandom());
    tx_idle_pct = 58; rx_idle_pct = 16;
    random_phase(260);
    drain();

    // long receiver hold-off while the sender keeps offering
    write_init_value(32'h0000_0000);
    tx_idle_pct = 0; rx_idle_pct = 0;
    hold_req++;
    random_phase(290);
    drain();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
